@@ src/rsm_pkg.sv @@
// Shared constants and types for the row softmax core.
package rsm_pkg;

    localparam int MAX_ROW     = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int LOGIT_W     = 16;
    localparam int PROB_W      = 17;
    localparam int SUM_W       = 23;
    localparam int SQ_STEPS    = 16;
    localparam int DIV_STEPS   = 16;
    localparam int SQ_CNT_W    = $clog2(SQ_STEPS);
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

    typedef struct packed {
        logic               start;
        logic [LOGIT_W-1:0] gap;
    } exp_req_t;

    typedef struct packed {
        logic              done;
        logic [PROB_W-1:0] value;
    } unit_rsp_t;

    typedef struct packed {
        logic              start;
        logic [PROB_W-1:0] num;
        logic [SUM_W-1:0]  den;
    } div_req_t;

endpackage

@@ src/row_softmax_core.sv @@
// Top level of the row softmax core: row memories, sequencer and output register.
//
// Usage: logits arrive on the s_ channel, one signed Q8.8 value per transfer,
// with s_tlast on the final element of a row. The core stores each element in
// a 64-entry row memory and tracks the running maximum, one transfer per cycle.
// After the last element, s_tready drops while the core walks the row twice:
// first it reads each element, runs the exponential unit (16 squarings, none
// for an element equal to the maximum) and writes the result to an exp memory
// while summing; then it reads each exp back and runs the divider (one
// quotient bit at a time) to produce the Q1.16 probability on the m_ channel,
// tlast on the last one and tuser set when the row ran past 64 elements
// (extra elements are dropped). The memories have a registered read; writes
// and reads never target the same memory in the same phase, so no forwarding
// is needed. A stalled m_tready holds the output register and stalls the
// divide walk; loading of the next row resumes once the last probability
// sits in the output register. Reset clears the sequencer, counters and sum
// and sets the maximum to the most negative logit; memory contents are left
// as they are and only written entries are read.
module row_softmax_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] logit
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] prob, [23:17] zero
    output logic        m_tlast,
    output logic        m_tuser    // [0] overflow
);
    import rsm_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_E_RD,
        ST_E_GO,
        ST_E_WAIT,
        ST_D_RD,
        ST_D_GO,
        ST_D_WAIT,
        ST_D_OUT
    } state_t;

    state_t                    state_reg;
    logic signed [LOGIT_W-1:0] max_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      ovf_reg;
    logic [ADDR_W-1:0]         k_reg;
    logic                      out_valid_reg;
    logic [PROB_W-1:0]         prob_reg;
    logic                      last_reg;
    logic                      oflag_reg;

    logic [LOGIT_W-1:0] row_mem [STORE_DEPTH];
    logic [PROB_W-1:0]  exp_mem [STORE_DEPTH];
    logic [LOGIT_W-1:0] row_rd_reg;
    logic [PROB_W-1:0]  exp_rd_reg;

    exp_req_t  exp_req;
    unit_rsp_t exp_rsp;
    div_req_t  div_req;
    unit_rsp_t div_rsp;

    logic                      in_xfer;
    logic                      store_ok;
    logic signed [LOGIT_W-1:0] logit;
    logic signed [LOGIT_W:0]   dist_full;
    logic                      at_end;
    logic                      out_free;
    logic                      out_load;

    assign s_tready  = (state_reg == ST_LOAD);
    assign in_xfer   = s_tvalid && s_tready;
    assign logit     = signed'(s_tdata);
    assign store_ok  = count_reg < CNT_W'(MAX_ROW);
    assign dist_full = {max_reg[LOGIT_W-1], max_reg}
                     - {row_rd_reg[LOGIT_W-1], row_rd_reg};
    assign at_end    = (CNT_W'(k_reg) + 1'b1) == count_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = (state_reg == ST_D_OUT) && out_free;

    assign exp_req.start = (state_reg == ST_E_GO);
    assign exp_req.gap   = dist_full[LOGIT_W-1:0];
    assign div_req.start = (state_reg == ST_D_GO);
    assign div_req.num   = exp_rd_reg;
    assign div_req.den   = sum_reg;

    rsm_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (exp_req),
        .rsp   (exp_rsp)
    );

    rsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Row memory: written during load, read during the exp walk
    always_ff @(posedge clk)
    begin
        if (in_xfer && store_ok)
            row_mem[count_reg[ADDR_W-1:0]] <= s_tdata;
        row_rd_reg <= row_mem[k_reg];
    end

    // Exp memory: written during the exp walk, read during the divide walk
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_E_WAIT && exp_rsp.done)
            exp_mem[k_reg] <= exp_rsp.value;
        exp_rd_reg <= exp_mem[k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            max_reg       <= signed'(LOGIT_W'(1) << (LOGIT_W - 1));
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            prob_reg      <= '0;
            last_reg      <= 1'b0;
            oflag_reg     <= 1'b0;
        end
        else
        begin
            // Drop valid after the transfer unless a new probability loads
            if (out_valid_reg && m_tready && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_LOAD:
                begin
                    if (in_xfer)
                    begin
                        if (store_ok)
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (logit > max_reg)
                                max_reg <= logit;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast)
                        begin
                            k_reg     <= '0;
                            sum_reg   <= '0;
                            state_reg <= ST_E_RD;
                        end
                    end
                end
                ST_E_RD:   state_reg <= ST_E_GO;
                ST_E_GO:   state_reg <= ST_E_WAIT;
                ST_E_WAIT:
                begin
                    if (exp_rsp.done)
                    begin
                        sum_reg <= sum_reg + SUM_W'(exp_rsp.value);
                        if (at_end)
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_D_RD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_E_RD;
                        end
                    end
                end
                ST_D_RD:   state_reg <= ST_D_GO;
                ST_D_GO:   state_reg <= ST_D_WAIT;
                ST_D_WAIT:
                begin
                    if (div_rsp.done)
                        state_reg <= ST_D_OUT;
                end
                ST_D_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        prob_reg      <= div_rsp.value;
                        last_reg      <= at_end;
                        oflag_reg     <= ovf_reg;
                        if (at_end)
                        begin
                            k_reg     <= '0;
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            max_reg   <= signed'(LOGIT_W'(1) << (LOGIT_W - 1));
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_D_RD;
                        end
                    end
                end
                default:   state_reg <= ST_LOAD;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, prob_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = oflag_reg;

`ifndef ASSERT_OFF
    // The row count never passes the row limit
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ROW))
        else $error("row count beyond limit");

    // Outside loading the row is never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_LOAD |-> count_reg != '0)
        else $error("walk over an empty row");

    // The maximum element alone contributes 1.0 to the sum before division
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_D_GO |-> sum_reg >= SUM_W'(ONE_Q16))
        else $error("exp sum below 1.0");

    // A probability never exceeds 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_D_OUT && out_free) |=> prob_reg <= ONE_Q16)
        else $error("probability above 1.0");
`endif

endmodule

@@ src/rsm_exp.sv @@
// Iterative exp(-d/256) unit: sixteen repeated squarings of a Q0.32 value.
module rsm_exp (
    input  logic              clk,
    input  logic              rst_n,
    input  rsm_pkg::exp_req_t req,
    output rsm_pkg::unit_rsp_t rsp
);
    import rsm_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [31:0]         r_reg;
    logic [PROB_W-1:0]   e_reg;
    logic [63:0]         sq;
    logic [32:0]         r_init;

    assign sq     = 64'(r_reg) * 64'(r_reg);
    assign r_init = 33'h1_0000_0000 - {9'b0, req.gap, 8'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= '0;
                if (req.gap == '0)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQ_CNT_W'(SQ_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            r_reg <= r_init[31:0];
            e_reg <= ONE_Q16;
        end
        else if (busy_reg)
        begin
            r_reg <= sq[63:32];
            e_reg <= {1'b0, sq[63:48]};
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = e_reg;

endmodule

@@ src/rsm_div.sv @@
// Restoring divider: floor(num * 2^16 / den), one quotient bit per cycle.
module rsm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rsm_pkg::div_req_t  req,
    output rsm_pkg::unit_rsp_t rsp
);
    import rsm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [PROB_W-1:0]    q_reg;
    logic [SUM_W:0]       rem2;
    logic                 fits;
    logic                 ge0;
    logic [SUM_W-1:0]     num_x;

    assign num_x = SUM_W'(req.num);
    assign ge0   = num_x >= req.den;
    assign rem2  = {rem_reg, 1'b0};
    assign fits  = rem2 >= {1'b0, req.den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // den must hold steady while busy
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= PROB_W'(ge0);
            rem_reg <= ge0 ? (num_x - req.den) : num_x;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[PROB_W-2:0], fits};
            rem_reg <= fits ? SUM_W'(rem2 - {1'b0, req.den}) : rem2[SUM_W-1:0];
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = q_reg;

endmodule
